FILE: src/lhcm_pkg.sv
// ----------------------------------------------------------------------------
// lhcm_pkg: shared constants, types and functions of the heat colour map
// Widths derived from the count width, the 5.8 log helper and the beat tag
// that travels with each pixel through the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package lhcm_pkg;

   // count width actually used (9 to 32)
   localparam int COUNT_BITS = 32;
   // width of the count and peak ports
   localparam int FIELD_BITS = 32;
   // integer part of the log: bit position of the leading one
   localparam int MSB_BITS   = $clog2(COUNT_BITS);
   // 5.8 log value
   localparam int LOG_BITS   = MSB_BITS + 8;
   // log times the level span (span fits in 8 bits)
   localparam int NUM_BITS   = LOG_BITS + 8;
   // quotient bits kept; anything at or above 256 saturates anyway
   localparam int QUO_BITS   = 8;
   localparam int COLOR_BITS = 8;
   localparam int LEVEL_BITS = 8;

   localparam logic [LEVEL_BITS:0]   LEVEL_BASE = 9'd16;
   localparam logic [7:0]            LEVEL_SPAN = 8'd239;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = 8'd255;
   localparam logic [COLOR_BITS-1:0] BLUE_FLOOR = 8'd64;
   localparam logic [COLOR_BITS-1:0] COLOR_MAX  = 8'hFF;

   // ramp segments, picked by the two top bits of the level
   localparam logic [1:0] SEG_BLUE    = 2'd0;
   localparam logic [1:0] SEG_MAGENTA = 2'd1;
   localparam logic [1:0] SEG_YELLOW  = 2'd2;
   localparam logic [1:0] SEG_WHITE   = 2'd3;

   // control that travels alongside a pixel
   typedef struct packed {
      logic valid;
      logic nz;     // count was nonzero
   } lhcm_beat_type;

   // 5.8 base-2 log: leading-one position and the eight bits below it
   function automatic logic [LOG_BITS-1:0] log2_q8(input logic [COUNT_BITS-1:0] v);
      logic [MSB_BITS-1:0]     msb;
      logic [COUNT_BITS+7:0]   ext;
      msb = '0;
      for (int b = 0; b < COUNT_BITS; b++) begin
         if (v[b]) begin
            msb = MSB_BITS'(b);
         end
      end
      ext = {v, 8'h00} >> msb;
      return {msb, ext[7:0]};
   endfunction

endpackage

`default_nettype wire

FILE: src/lhcm_qdiv.sv
// ----------------------------------------------------------------------------
// lhcm_qdiv: pipelined restoring divider for the level quotient
// One compare stage flags quotients of 256 or more (this also covers a zero
// divisor), then eight stages each settle one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lhcm_qdiv
   import lhcm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lhcm_beat_type         in_beat,
   input  wire logic [NUM_BITS-1:0]   in_num,
   input  wire logic [LOG_BITS-1:0]   top,
   output lhcm_beat_type              out_beat,
   output logic [QUO_BITS-1:0]        out_quo,
   output logic                       out_over
);

   localparam int STAGES = QUO_BITS + 1;

   logic [STAGES-1:0]   vld_ff,  vld_in;
   logic [STAGES-1:0]   nz_ff,   nz_in;
   logic [STAGES-1:0]   over_ff, over_in;
   logic [NUM_BITS-1:0] rem_ff [STAGES];
   logic [NUM_BITS-1:0] rem_in [STAGES];
   logic [QUO_BITS-1:0] quo_ff [STAGES];
   logic [QUO_BITS-1:0] quo_in [STAGES];

   // stage 0: range check, later stages: one quotient bit each
   always_comb begin
      logic [NUM_BITS-1:0] dsr;
      vld_in[0]  = in_beat.valid;
      nz_in[0]   = in_beat.nz;
      over_in[0] = in_num >= (NUM_BITS'(top) << QUO_BITS);
      rem_in[0]  = in_num;
      quo_in[0]  = '0;
      for (int j = 1; j < STAGES; j++) begin
         dsr        = NUM_BITS'(top) << (QUO_BITS - j);
         vld_in[j]  = vld_ff[j-1];
         nz_in[j]   = nz_ff[j-1];
         over_in[j] = over_ff[j-1];
         quo_in[j]  = quo_ff[j-1];
         rem_in[j]  = rem_ff[j-1];
         if (rem_ff[j-1] >= dsr) begin
            rem_in[j]              = rem_ff[j-1] - dsr;
            quo_in[j][QUO_BITS-j]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      nz_ff   <= nz_in;
      over_ff <= over_in;
      for (int j = 0; j < STAGES; j++) begin
         rem_ff[j] <= rem_in[j];
         quo_ff[j] <= quo_in[j];
      end
   end

   assign out_beat.valid = vld_ff[STAGES-1];
   assign out_beat.nz    = nz_ff[STAGES-1];
   assign out_quo        = quo_ff[STAGES-1];
   assign out_over       = over_ff[STAGES-1];

   // in-range quotient leaves a remainder below the divisor
   a_rem_below_top: assert property (@(posedge clock) disable iff (reset)
      (out_beat.valid && !out_over) |-> (rem_ff[STAGES-1] < NUM_BITS'(top)))
      else $error("divider remainder not below divisor");

   // every beat out matches a beat that entered through stage 0
   a_latency: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-1] |-> $past(in_beat.valid, STAGES))
      else $error("divider beat without matching entry");

   // a zero divisor always takes the saturating path
   a_zero_top: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && (top == '0)) |-> over_ff[0])
      else $error("zero divisor not flagged");

endmodule

`default_nettype wire

FILE: src/log_heat_colour_map_core.sv
// ----------------------------------------------------------------------------
// log_heat_colour_map_core: event count to RGB heat color, log scale
// Pipelined map from a pixel's event count to a blue-magenta-yellow-white
// ramp, scaled by the log of a programmed peak count.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock where start is high and busy is low, one per
// cycle with no gaps, and its color appears on rsp_red/green/blue with a
// one-cycle rsp_valid strobe after the capture, log, scale, divider, level and
// color registers; the receiver cannot stall, so it must take every strobe. The
// nine-stage restoring divider (a range check, then one stage per quotient bit)
// forms the level. busy is registered reset: high during reset and in the cycle
// after it. The user must write the peak count through csr_valid/csr_ready only
// while no pixel is in flight (the block does not enforce this); its log is
// computed at the write and held, so a pixel may follow the write in the next cycle.
`default_nettype none

module log_heat_colour_map_core
   import lhcm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel input
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [FIELD_BITS-1:0]  req_event_count,
   // color output
   output logic                        rsp_valid,
   output logic [COLOR_BITS-1:0]       rsp_red,
   output logic [COLOR_BITS-1:0]       rsp_green,
   output logic [COLOR_BITS-1:0]       rsp_blue,
   // peak register write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [FIELD_BITS-1:0]  csr_peak_count
);

   localparam int LATENCY = QUO_BITS + 6;

   logic                   busy_ff;
   logic [LOG_BITS-1:0]    top_ff;
   lhcm_beat_type          cnt_beat_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   lhcm_beat_type          log_beat_ff;
   logic [LOG_BITS-1:0]    log_ff;
   lhcm_beat_type          num_beat_ff;
   logic [NUM_BITS-1:0]    num_ff;
   lhcm_beat_type          div_beat;
   logic [QUO_BITS-1:0]    div_quo;
   logic                   div_over;
   lhcm_beat_type          lvl_beat_ff;
   logic [LEVEL_BITS-1:0]  lvl_ff, lvl_in;
   logic                   rsp_valid_ff;
   logic [COLOR_BITS-1:0]  red_ff, red_in;
   logic [COLOR_BITS-1:0]  green_ff, green_in;
   logic [COLOR_BITS-1:0]  blue_ff, blue_in;
   logic                   accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // peak register, kept as its 5.8 log (reset peak of one logs to zero)
   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         top_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         top_ff <= log2_q8(csr_peak_count[COUNT_BITS-1:0]);
      end
   end

   // front stages: capture, log of the count, scale by the level span
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_beat_ff <= '0;
         log_beat_ff <= '0;
         num_beat_ff <= '0;
      end else begin
         cnt_beat_ff.valid <= accept;
         cnt_beat_ff.nz    <= req_event_count[COUNT_BITS-1:0] != '0;
         log_beat_ff       <= cnt_beat_ff;
         num_beat_ff       <= log_beat_ff;
      end
      cnt_ff <= req_event_count[COUNT_BITS-1:0];
      log_ff <= log2_q8(cnt_ff);
      num_ff <= NUM_BITS'(log_ff) * NUM_BITS'(LEVEL_SPAN);
   end

   lhcm_qdiv u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (num_beat_ff),
      .in_num   (num_ff),
      .top      (top_ff),
      .out_beat (div_beat),
      .out_quo  (div_quo),
      .out_over (div_over)
   );

   // level: offset, saturate at full scale
   always_comb begin
      logic [LEVEL_BITS:0] sum;
      sum = LEVEL_BASE + (LEVEL_BITS+1)'(div_quo);
      if (div_over || sum > (LEVEL_BITS+1)'(LEVEL_MAX)) begin
         lvl_in = LEVEL_MAX;
      end else begin
         lvl_in = sum[LEVEL_BITS-1:0];
      end
   end

   // ramp: four segments of 64 levels each
   always_comb begin
      logic [COLOR_BITS-1:0] step4;
      logic [COLOR_BITS-1:0] step3;
      step4    = {lvl_ff[5:0], 2'b00};
      step3    = BLUE_FLOOR + {1'b0, lvl_ff[5:0], 1'b0} + {2'b00, lvl_ff[5:0]};
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (lvl_beat_ff.nz) begin
         case (lvl_ff[7:6])
            SEG_BLUE: begin
               blue_in = step3;
            end
            SEG_MAGENTA: begin
               red_in  = step4;
               blue_in = COLOR_MAX;
            end
            SEG_YELLOW: begin
               red_in   = COLOR_MAX;
               green_in = step4;
               blue_in  = COLOR_MAX - step4;
            end
            SEG_WHITE: begin
               red_in   = COLOR_MAX;
               green_in = COLOR_MAX;
               blue_in  = step4;
            end
         endcase
      end
   end

   // back stages: level register, color output register
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_beat_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lvl_beat_ff  <= div_beat;
         rsp_valid_ff <= lvl_beat_ff.valid;
      end
      lvl_ff   <= lvl_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // every color beat comes from a pixel taken a fixed time earlier
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("color beat without a matching pixel");

   // a nonzero count never maps below the base level
   a_level_floor: assert property (@(posedge clock) disable iff (reset)
      (lvl_beat_ff.valid && lvl_beat_ff.nz) |-> (lvl_ff >= LEVEL_BASE[LEVEL_BITS-1:0]))
      else $error("level below base");

   // green only appears once red is full
   a_green_after_red: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_green != '0)) |-> (rsp_red == COLOR_MAX))
      else $error("green without full red");

endmodule

`default_nettype wire
